// ===== design/sptseq_pkg.sv =====
`default_nettype none

package sptseq_pkg;

	// Table geometry: four groups of eight servo slots plus one remainder slot each.
	localparam int unsigned NUM_GROUPS = 4;
	localparam int unsigned SERVO_SLOTS = 8;
	localparam int unsigned NUM_SERVO_ENTRIES = NUM_GROUPS * SERVO_SLOTS;

	localparam logic [3:0] REST_SLOT = 4'd8;

	// Reset contents of the pulse tables and the compare registers, in timer clocks.
	localparam logic [15:0] RESET_SERVO_CLOCKS = 16'd3000;
	localparam logic [15:0] RESET_REST_CLOCKS = 16'd17000;
	localparam logic [15:0] RESET_COMPARE = 16'd2000;

	// Configuration register indexes and reset values.
	localparam logic [1:0] REG_CLOCK_SCALE = 2'd0;
	localparam logic [1:0] REG_PULSE_MIN = 2'd1;
	localparam logic [1:0] REG_PULSE_MAX = 2'd2;

	localparam logic [17:0] RESET_CLOCK_SCALE = 18'd131072;
	localparam logic [15:0] RESET_PULSE_MIN = 16'd500;
	localparam logic [15:0] RESET_PULSE_MAX = 16'd2500;

	// Operation codes carried on the input tuser.
	localparam logic OP_SET_POSITION = 1'b0;
	localparam logic OP_COMPARE_EVENT = 1'b1;

	// Fields carried from the clamp/scale stage into the state update stage.
	typedef struct packed {
		logic        op;
		logic        ok;
		logic [4:0]  addr;
		logic [1:0]  grp;
		logic [15:0] clocks;
	} stage2_t;

	// Pin map: servo number to table slot. Servos 16..31 use the low servos' map
	// with the two low slot bits inverted.
	function automatic logic [2:0] slot_of_servo(input logic [4:0] servo);
		logic [2:0] base;
		unique case (servo[2:0])
			3'd0: base = 3'd7;
			3'd1: base = 3'd3;
			3'd2: base = 3'd2;
			3'd3: base = 3'd6;
			3'd4: base = 3'd5;
			3'd5: base = 3'd1;
			3'd6: base = 3'd0;
			3'd7: base = 3'd4;
			default: base = 3'd0;
		endcase
		return base ^ {1'b0, servo[4], servo[4]};
	endfunction

endpackage

`default_nettype wire

// ===== design/servo_pulse_train_sequencer.sv =====
`default_nettype none

// Servo pulse train sequencer for 32 servos driven as four groups of eight through
// decade-counter clock lines. A set-position request (tuser 0) clamps the pulse
// to the configured limits, scales microseconds to timer clocks as
// (us * clock_scale) >> 16, stores the result in the slot picked by the fixed pin
// map, and corrects the group's remainder slot so the frame length stays constant
// (all modulo 2^16). Servo numbers above 31 are rejected with an all-zero result.
// A compare-event request (tuser 1) adds the clocks of the group's current slot
// to its compare value and advances the slot cursor; after the remainder slot the
// cursor wraps and the result carries tlast, marking the forced counter reset.
// Every request yields exactly one result. The block takes one request per clock
// cycle while the output is not stalled; a request passes through the input
// register, the clamp and multiply stage and the state update stage into the
// output register. The read-modify-write of the pulse table and compare
// registers in the update stage lets each request see the state left by the
// one before it. Stalls on the output side fill the pipeline bubbles first and
// only then push back on the input. Configuration registers are written through
// wr_en/wr_index/wr_data and must only change while no request is in flight.
module servo_pulse_train_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Configuration write port: 0 clock_scale, 1 pulse_min_us, 2 pulse_max_us.
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [17:0] wr_data,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// servo [5:0], pulse_us [21:6], group [23:22]
	input  wire logic [23:0] s_axis_tdata,
	// operation [0]
	input  wire logic [0:0]  s_axis_tuser,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// compare_value [15:0], slot_used [19:16], stored_clocks [35:20], accepted [36],
	// zero fill [39:37]
	output logic [39:0]      m_axis_tdata,
	// frame_end
	output logic             m_axis_tlast
);

	// Configuration registers.
	logic [17:0] clock_scale_q;
	logic [15:0] pulse_min_q;
	logic [15:0] pulse_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_scale_q <= sptseq_pkg::RESET_CLOCK_SCALE;
			pulse_min_q   <= sptseq_pkg::RESET_PULSE_MIN;
			pulse_max_q   <= sptseq_pkg::RESET_PULSE_MAX;
		end else if (wr_en) begin
			unique case (wr_index)
				sptseq_pkg::REG_CLOCK_SCALE: clock_scale_q <= wr_data;
				sptseq_pkg::REG_PULSE_MIN:   pulse_min_q <= wr_data[15:0];
				sptseq_pkg::REG_PULSE_MAX:   pulse_max_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake. Each stage moves on when its successor is empty or moving.
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic adv1;
	logic adv2;

	assign adv2          = !out_valid_q || m_axis_tready;
	assign adv1          = !valid_s2 || adv2;
	assign s_axis_tready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv1) begin
				valid_s2 <= valid_s1;
			end
			if (adv2) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Stage 1: registered request.
	logic        op_s1;
	logic [5:0]  servo_s1;
	logic [15:0] pulse_s1;
	logic [1:0]  grp_s1;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1    <= s_axis_tuser[0];
			servo_s1 <= s_axis_tdata[5:0];
			pulse_s1 <= s_axis_tdata[21:6];
			grp_s1   <= s_axis_tdata[23:22];
		end
	end

	// Clamp to the limits (the minimum is tested first), then scale.
	logic [15:0]         pulse_clamped;
	logic [33:0]         product;
	sptseq_pkg::stage2_t next_s2;

	always_comb begin
		if (pulse_s1 < pulse_min_q) begin
			pulse_clamped = pulse_min_q;
		end else if (pulse_s1 > pulse_max_q) begin
			pulse_clamped = pulse_max_q;
		end else begin
			pulse_clamped = pulse_s1;
		end
		product = 34'(pulse_clamped) * 34'(clock_scale_q);

		next_s2.op     = op_s1;
		next_s2.ok     = (op_s1 == sptseq_pkg::OP_SET_POSITION) && !servo_s1[5];
		next_s2.addr   = {servo_s1[4:3], sptseq_pkg::slot_of_servo(servo_s1[4:0])};
		next_s2.grp    = grp_s1;
		next_s2.clocks = product[31:16];
	end

	sptseq_pkg::stage2_t req_s2;

	always_ff @(posedge clk) begin
		if (valid_s1 && adv1) begin
			req_s2 <= next_s2;
		end
	end

	// Stage 2: state read-modify-write. The servo slots are kept apart from the
	// remainder slots so that each store is read at a single address per cycle.
	logic [15:0] slots_q   [sptseq_pkg::NUM_SERVO_ENTRIES];
	logic [15:0] rest_q    [sptseq_pkg::NUM_GROUPS];
	logic [15:0] compare_q [sptseq_pkg::NUM_GROUPS];
	logic [3:0]  cursor_q  [sptseq_pkg::NUM_GROUPS];

	logic        fire2;
	logic [3:0]  cur_eff;
	logic        is_rest;
	logic [4:0]  slot_addr;
	logic [1:0]  rest_idx;
	logic [15:0] slot_rd;
	logic [15:0] rest_rd;
	logic [15:0] add_clocks;
	logic [15:0] compare_new;
	logic [15:0] rest_new;
	logic [3:0]  cursor_new;

	assign fire2 = valid_s2 && adv2;

	always_comb begin
		cur_eff = (cursor_q[req_s2.grp] > sptseq_pkg::REST_SLOT) ?
			sptseq_pkg::REST_SLOT : cursor_q[req_s2.grp];
		is_rest = (cur_eff == sptseq_pkg::REST_SLOT);

		if (req_s2.op == sptseq_pkg::OP_COMPARE_EVENT) begin
			slot_addr = {req_s2.grp, cur_eff[2:0]};
			rest_idx  = req_s2.grp;
		end else begin
			slot_addr = req_s2.addr;
			rest_idx  = req_s2.addr[4:3];
		end
		slot_rd = slots_q[slot_addr];
		rest_rd = rest_q[rest_idx];

		add_clocks  = is_rest ? rest_rd : slot_rd;
		compare_new = compare_q[req_s2.grp] + add_clocks;
		cursor_new  = is_rest ? 4'd0 : cur_eff + 4'd1;
		// Whatever the slot gains, the remainder gives up, so the frame stays fixed.
		rest_new    = rest_rd + slot_rd - req_s2.clocks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sptseq_pkg::NUM_SERVO_ENTRIES; i++) begin
				slots_q[i] <= sptseq_pkg::RESET_SERVO_CLOCKS;
			end
			for (int g = 0; g < sptseq_pkg::NUM_GROUPS; g++) begin
				rest_q[g]    <= sptseq_pkg::RESET_REST_CLOCKS;
				compare_q[g] <= sptseq_pkg::RESET_COMPARE;
				cursor_q[g]  <= 4'd0;
			end
		end else if (fire2) begin
			if (req_s2.op == sptseq_pkg::OP_COMPARE_EVENT) begin
				compare_q[req_s2.grp] <= compare_new;
				cursor_q[req_s2.grp]  <= cursor_new;
			end else if (req_s2.ok) begin
				slots_q[slot_addr] <= req_s2.clocks;
				rest_q[rest_idx]   <= rest_new;
			end
		end
	end

	// Output register. Fields an operation does not use are zero, and a rejected
	// set-position request gives an all-zero result.
	logic [15:0] compare_value_q;
	logic        frame_end_q;
	logic [3:0]  slot_used_q;
	logic [15:0] stored_clocks_q;
	logic        accepted_q;

	always_ff @(posedge clk) begin
		if (fire2) begin
			if (req_s2.op == sptseq_pkg::OP_COMPARE_EVENT) begin
				compare_value_q <= compare_new;
				frame_end_q     <= is_rest;
				slot_used_q     <= cur_eff;
				stored_clocks_q <= 16'd0;
				accepted_q      <= 1'b0;
			end else begin
				compare_value_q <= 16'd0;
				frame_end_q     <= 1'b0;
				slot_used_q     <= 4'd0;
				stored_clocks_q <= req_s2.ok ? req_s2.clocks : 16'd0;
				accepted_q      <= req_s2.ok;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = frame_end_q;
	assign m_axis_tdata  = {3'b000, accepted_q, stored_clocks_q, slot_used_q, compare_value_q};

endmodule

`default_nettype wire
